>>> design/fra_pkg.sv
package fra_pkg;

    // request kinds; the remaining code is a no-op
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_TRY   = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NONE      = 2'd1,
        STS_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    localparam int HANDLE_W  = 8;
    localparam int POOL_SLOTS = 256;
    localparam int COUNT_W   = 9;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } t_dp_sts;

endpackage

>>> design/fra_ram.sv
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/fra_ctrl.sv
module fra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fra_pkg::t_dp_sts  i_sts,
    output fra_pkg::t_ctl_cmd o_cmd
);

    fra_pkg::t_state r_state;
    fra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            fra_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fra_pkg::S_READ;
                end
            end
            // ram read data settles
            fra_pkg::S_READ: begin
                n_state = fra_pkg::S_EXEC;
            end
            fra_pkg::S_EXEC: begin
                if (!i_sts.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = fra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/fra_dp.sv
module fra_dp #(
    parameter int MAX_HANDLES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fra_pkg::t_ctl_cmd i_cmd,
    output fra_pkg::t_dp_sts  o_sts,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_handle,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_handle_out,
    output logic [1:0]        o_status
);

    localparam int LIMIT_INT = (MAX_HANDLES < fra_pkg::POOL_SLOTS) ?
                               MAX_HANDLES : fra_pkg::POOL_SLOTS;
    localparam logic [fra_pkg::COUNT_W-1:0] POOL_LIMIT = fra_pkg::COUNT_W'(LIMIT_INT);
    localparam logic [fra_pkg::COUNT_W-1:0] SLOTS      = fra_pkg::COUNT_W'(fra_pkg::POOL_SLOTS);

    // latched request
    logic [1:0] r_op;
    logic [7:0] r_handle;

    // queue and counter state
    logic [7:0]                  r_head;
    logic [7:0]                  r_tail;
    logic [fra_pkg::COUNT_W-1:0] r_count;
    logic [fra_pkg::COUNT_W-1:0] r_fresh;
    logic [fra_pkg::POOL_SLOTS-1:0] r_map_vld;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_handle;
    logic [1:0] r_out_status;

    // ram ports
    logic       map_we;
    logic [7:0] map_waddr;
    logic       map_wdata;
    logic       map_rdata;
    logic       q_we;
    logic [7:0] q_rdata;

    // commit results
    logic       pop;
    logic       push;
    logic       fresh_take;
    logic [7:0] got;
    logic [1:0] status;
    logic       map_bit;

    fra_ram #(.WIDTH(1), .DEPTH(fra_pkg::POOL_SLOTS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_handle),
        .o_rdata (map_rdata)
    );

    fra_ram #(.WIDTH(8), .DEPTH(fra_pkg::POOL_SLOTS)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (r_handle),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    // never-written map entries read as free
    assign map_bit = r_map_vld[r_handle] & map_rdata;

    always_comb begin
        pop        = 1'b0;
        push       = 1'b0;
        fresh_take = 1'b0;
        got        = 8'd0;
        status     = fra_pkg::STS_OK;
        map_we     = 1'b0;
        map_waddr  = r_handle;
        map_wdata  = 1'b0;
        case (r_op)
            fra_pkg::OP_ALLOC: begin
                if (r_count != '0) begin
                    pop       = 1'b1;
                    got       = q_rdata;
                    map_we    = 1'b1;
                    map_waddr = q_rdata;
                    map_wdata = 1'b1;
                end else if (r_fresh < POOL_LIMIT) begin
                    fresh_take = 1'b1;
                    got        = r_fresh[7:0];
                    map_we     = 1'b1;
                    map_waddr  = r_fresh[7:0];
                    map_wdata  = 1'b1;
                end else begin
                    status = fra_pkg::STS_NONE;
                end
            end
            fra_pkg::OP_TRY: begin
                if (r_count != '0) begin
                    pop       = 1'b1;
                    got       = q_rdata;
                    map_we    = 1'b1;
                    map_waddr = q_rdata;
                    map_wdata = 1'b1;
                end else begin
                    status = fra_pkg::STS_NONE;
                end
            end
            fra_pkg::OP_FREE: begin
                if (!map_bit) begin
                    status = fra_pkg::STS_NOT_ALLOC;
                end else begin
                    map_we = 1'b1;
                    push   = (r_count < SLOTS);
                end
            end
            default: begin
                status = fra_pkg::STS_OK;
            end
        endcase
        map_we = map_we & i_cmd.commit;
    end

    assign q_we = push & i_cmd.commit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_handle <= i_handle;
        end
        if (i_cmd.commit) begin
            r_out_handle <= got;
            r_out_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_fresh   <= '0;
            r_map_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (map_we) begin
                r_map_vld[map_waddr] <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (pop) begin
                    r_head  <= r_head + 8'd1;
                    r_count <= r_count - fra_pkg::COUNT_W'(1);
                end
                if (push) begin
                    r_tail  <= r_tail + 8'd1;
                    r_count <= r_count + fra_pkg::COUNT_W'(1);
                end
                if (fresh_take) begin
                    r_fresh <= r_fresh + fra_pkg::COUNT_W'(1);
                end
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.out_stall = r_out_vld & ~i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_handle_out    = r_out_handle;
    assign o_status        = r_out_status;

endmodule

>>> design/fifo_reuse_handle_allocator_unit.sv
// channel   dir  tdata             tuser
// s_axis    in   [7:0] handle      [1:0] operation
// m_axis    out  [7:0] handle_out  [1:0] status
//
// each request steps through accept, a read of the bitmap and free-queue
// rams, then commit into the output register; the ram read is registered
// s_axis_tready is high only while the unit waits for a request
// a held result does not block acceptance of the next request; only the
// commit waits while the output register is full and not taken
// synchronous active-low reset clears the bitmap valid bits, queue pointers,
// fresh counter and output valid; no clearing pass is needed
module fifo_reuse_handle_allocator_unit #(
    parameter int MAX_HANDLES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] handle
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] handle_out
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    // command and status between controller and datapath
    fra_pkg::t_ctl_cmd cmd;
    fra_pkg::t_dp_sts  sts;

    // sequencer: idle, ram read, commit
    fra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // bitmap, free queue, fresh counter and output register
    fra_dp #(.MAX_HANDLES(MAX_HANDLES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_handle     (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_handle_out (m_axis_tdata),
        .o_status     (m_axis_tuser)
    );

endmodule

>>> design/fra_checker.sv
module fra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one request in flight at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // failed requests grant no handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != fra_pkg::STS_OK) |-> m_axis_tdata == 8'd0)
        else $error("handle given with error status");

    // only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == fra_pkg::STS_OK) ||
            (m_axis_tuser == fra_pkg::STS_NONE) || (m_axis_tuser == fra_pkg::STS_NOT_ALLOC))
        else $error("undefined status code");

endmodule

bind fifo_reuse_handle_allocator_unit fra_checker u_fra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
